// ===== rtl/particle_pool_update_defines.svh =====
// Assertion macros shared by the particle pool RTL.
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every clock edge out of reset.
`define PPU_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PPU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPU_ASSERT(label, ante, cons)
`define PPU_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/ppu_pkg.sv =====
// Types and constants of the particle pool.
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

  localparam int SLOT_W = 6;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_GMASK = 2'd0,
    REG_GACC  = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic               op;
    logic [31:0]        now;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [3:0]         kind;
    logic [23:0]        life;
    logic [15:0]        step;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [3:0]         out_kind;
    logic               present;
    logic               accepted;
    logic               last;
  } out_item_t;

  // One pool entry as stored in memory.
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [3:0]         kind;
    logic [31:0]        death;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/ppu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ram #(
  parameter int W = 8,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ppu_alu.sv =====
// Shared multiply, round and saturating add unit: base + round(rate * step / 2^16).
`timescale 1ns / 1ps
`default_nettype none
module ppu_alu (
  input  wire logic               clk,
  input  wire logic signed [23:0] rate,
  input  wire logic [15:0]        step,
  input  wire logic signed [23:0] base,
  output logic signed [23:0]      res
);

  logic signed [40:0] prod_r;
  logic signed [41:0] rnd;
  logic signed [25:0] inc;
  logic signed [26:0] sum;

  // multiply stage
  always_ff @(posedge clk) begin
    prod_r <= 41'(rate) * 41'($signed({1'b0, step}));
  end

  // round half up, add, saturate
  always_comb begin
    rnd = 42'(prod_r) + 42'sd32768;
    inc = 26'(rnd >>> 16);
    sum = 27'(base) + 27'(inc);
    if (sum > 27'sd8388607) begin
      res = 24'sh7FFFFF;
    end else if (sum < -27'sd8388608) begin
      res = 24'sh800000;
    end else begin
      res = 24'(sum);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/particle_pool_update.sv =====
// Particle pool: add, expire-and-compact, and fixed-point move sequencer.
// Add: one result in the cycle after the accepting edge; busy stays low.
// Tick: a kill pass drops entries with death <= now, filling gaps with the last entry; then
// a move pass updates each survivor, one result per survivor (one empty result if none).
// The shared multiplier unit and the single RAM read port set the pace of the tick.
// Synchronous reset empties the pool and loads register defaults; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_pool_update_defines.svh"
module particle_pool_update #(
  parameter int POOL_SIZE = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ppu_pkg::in_item_t    in_item,
  output logic                      out_valid,
  output ppu_pkg::out_item_t        out_item,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [23:0]          cfg_data
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int EW = $bits(ppu_pkg::entry_t);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_KRD   = 9'b000000010,
    S_KCHK  = 9'b000000100,
    S_KCOPY = 9'b000001000,
    S_MRD   = 9'b000010000,
    S_MLD   = 9'b000100000,
    S_MMUL  = 9'b001000000,
    S_MADD  = 9'b010000000,
    S_MWR   = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [1:0]          ax_r, ax_nxt;
  logic [31:0]         now_r, now_nxt;
  logic [15:0]         step_r, step_nxt;
  logic [15:0]         gmask_r;
  logic signed [23:0]  gacc_r;
  ppu_pkg::entry_t     ent_r, ent_nxt;
  logic                ov_r, ov_nxt;
  ppu_pkg::out_item_t  oi_r, oi_nxt;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  ppu_pkg::entry_t     wdata, rdata;
  logic [EW-1:0]       rdata_w;

  logic                accept;
  logic [CW-1:0]       lastidx;
  logic [CW-1:0]       idx_inc;
  logic                grav;
  logic signed [23:0]  alu_rate, alu_base, alu_res;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign lastidx = cnt_r - 1'b1;
  assign idx_inc = idx_r + 1'b1;
  assign grav    = gmask_r[ent_r.kind];
  assign rdata   = ppu_pkg::entry_t'(rdata_w);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  ppu_ram #(.W(EW), .D(POOL_SIZE)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (EW'(wdata)),
    .raddr (raddr),
    .rdata (rdata_w)
  );

  // select operands of the shared unit by axis
  always_comb begin
    case (ax_r)
      2'd0:    begin alu_rate = ent_r.vel_x; alu_base = ent_r.pos_x; end
      2'd1:    begin alu_rate = ent_r.vel_y; alu_base = ent_r.pos_y; end
      2'd2:    begin alu_rate = ent_r.vel_z; alu_base = ent_r.pos_z; end
      default: begin alu_rate = gacc_r;      alu_base = ent_r.vel_z; end
    endcase
  end

  ppu_alu u_alu (
    .clk  (clk),
    .rate (alu_rate),
    .step (step_r),
    .base (alu_base),
    .res  (alu_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ax_nxt    = ax_r;
    now_nxt   = now_r;
    step_nxt  = step_r;
    ent_nxt   = ent_r;
    ov_nxt    = 1'b0;
    oi_nxt    = '0;
    we        = 1'b0;
    waddr     = idx_r[AW-1:0];
    wdata     = ent_r;
    raddr     = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.op == ppu_pkg::OP_ADD) begin
            ov_nxt      = 1'b1;
            oi_nxt.last = 1'b1;
            if (32'(cnt_r) < 32'(POOL_SIZE)) begin
              we             = 1'b1;
              waddr          = cnt_r[AW-1:0];
              wdata.pos_x    = in_item.pos_x;
              wdata.pos_y    = in_item.pos_y;
              wdata.pos_z    = in_item.pos_z;
              wdata.vel_x    = in_item.vel_x;
              wdata.vel_y    = in_item.vel_y;
              wdata.vel_z    = in_item.vel_z;
              wdata.kind     = in_item.kind;
              wdata.death    = in_item.now + 32'(in_item.life);
              cnt_nxt        = cnt_r + 1'b1;
              oi_nxt.slot    = ppu_pkg::SLOT_W'(cnt_r);
              oi_nxt.out_x   = in_item.pos_x;
              oi_nxt.out_y   = in_item.pos_y;
              oi_nxt.out_z   = in_item.pos_z;
              oi_nxt.out_kind = in_item.kind;
              oi_nxt.present  = 1'b1;
              oi_nxt.accepted = 1'b1;
            end
          end else begin
            now_nxt   = in_item.now;
            step_nxt  = in_item.step;
            idx_nxt   = '0;
            state_nxt = S_KRD;
          end
        end
      end
      S_KRD: begin
        if (idx_r >= cnt_r) begin
          idx_nxt = '0;
          if (cnt_r == '0) begin
            ov_nxt      = 1'b1;
            oi_nxt.last = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_MRD;
          end
        end else begin
          state_nxt = S_KCHK;
        end
      end
      S_KCHK: begin
        if (rdata.death <= now_r) begin
          cnt_nxt = lastidx;
          if (idx_r < lastidx) begin
            raddr     = lastidx[AW-1:0];
            state_nxt = S_KCOPY;
          end else begin
            state_nxt = S_KRD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_KRD;
        end
      end
      S_KCOPY: begin
        we        = 1'b1;
        wdata     = rdata;
        state_nxt = S_KRD;
      end
      S_MRD: begin
        state_nxt = S_MLD;
      end
      S_MLD: begin
        ent_nxt   = rdata;
        ax_nxt    = 2'd0;
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        state_nxt = S_MADD;
      end
      S_MADD: begin
        case (ax_r)
          2'd0:    ent_nxt.pos_x = alu_res;
          2'd1:    ent_nxt.pos_y = alu_res;
          2'd2:    ent_nxt.pos_z = alu_res;
          default: ent_nxt.vel_z = alu_res;
        endcase
        if ((ax_r == 2'd3) || ((ax_r == 2'd2) && !grav)) begin
          state_nxt = S_MWR;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_MMUL;
        end
      end
      S_MWR: begin
        we              = 1'b1;
        ov_nxt          = 1'b1;
        oi_nxt.slot     = ppu_pkg::SLOT_W'(idx_r);
        oi_nxt.out_x    = ent_r.pos_x;
        oi_nxt.out_y    = ent_r.pos_y;
        oi_nxt.out_z    = ent_r.pos_z;
        oi_nxt.out_kind = ent_r.kind;
        oi_nxt.present  = 1'b1;
        oi_nxt.last     = (idx_inc == cnt_r);
        idx_nxt         = idx_inc;
        state_nxt       = (idx_inc == cnt_r) ? S_IDLE : S_MRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      gmask_r <= '0;
      gacc_r  <= -24'sd40960;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ppu_pkg::REG_GMASK: gmask_r <= cfg_data[15:0];
          ppu_pkg::REG_GACC:  gacc_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    ax_r   <= ax_nxt;
    now_r  <= now_nxt;
    step_r <= step_nxt;
    ent_r  <= ent_nxt;
    oi_r   <= oi_nxt;
  end

  `PPU_ASSERT(a_cnt_range, 1'b1, 32'(cnt_r) <= 32'(POOL_SIZE))
  `PPU_ASSERT_NXT(a_add_one_beat, accept && (in_item.op == ppu_pkg::OP_ADD), ov_r && oi_r.last && !busy)
  `PPU_ASSERT_NXT(a_tick_busy, accept && (in_item.op == ppu_pkg::OP_TICK), busy)
  `PPU_ASSERT(a_more_pending, ov_r && !oi_r.last, busy)
  `PPU_ASSERT(a_kill_walk, state_r == S_KCHK, idx_r < cnt_r)

endmodule
`default_nettype wire
